FILE: rtl/core/z80alu_pkg.sv
// ----------------------------------------------------------------------------
// z80alu_pkg
// Shared types and codes for the Z80 ALU: operation codes, flag bit
// positions and the request/response payloads.
// ----------------------------------------------------------------------------
package z80alu_pkg;

  // Operation codes. Codes 30 and 31 are unused and pass operand_a through.
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_ADD16 = 5'd10,
    OP_ADC16 = 5'd11,
    OP_SBC16 = 5'd12,
    OP_INC16 = 5'd13,
    OP_DEC16 = 5'd14,
    OP_RLC   = 5'd15,
    OP_RL    = 5'd16,
    OP_RRC   = 5'd17,
    OP_RR    = 5'd18,
    OP_RLCA  = 5'd19,
    OP_RLA   = 5'd20,
    OP_RRCA  = 5'd21,
    OP_RRA   = 5'd22,
    OP_SLA   = 5'd23,
    OP_SRA   = 5'd24,
    OP_SRL   = 5'd25,
    OP_SLL   = 5'd26,
    OP_BIT   = 5'd27,
    OP_SET   = 5'd28,
    OP_RES   = 5'd29
  } func_t;

  // Flag byte layout: S Z - H - PV N C
  localparam int unsigned FL_S  = 7;
  localparam int unsigned FL_Z  = 6;
  localparam int unsigned FL_H  = 4;
  localparam int unsigned FL_PV = 2;
  localparam int unsigned FL_N  = 1;
  localparam int unsigned FL_C  = 0;

  typedef struct packed {
    logic [4:0]  func;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [7:0]  flags_in;
  } req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags_out;
  } rsp_t;

endpackage

FILE: rtl/core/z80alu_if.sv
// ----------------------------------------------------------------------------
// z80alu_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface z80alu_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/z80alu_stage.sv
// ----------------------------------------------------------------------------
// z80alu_stage
// One pipeline register with valid bit; fills while downstream drains.
// ----------------------------------------------------------------------------
module z80alu_stage #(
  parameter type payload_t = logic
) (
  input  logic clk,
  input  logic rst,
  z80alu_if.sink   up,
  z80alu_if.source dn
);

  logic     valid;
  payload_t data;

  assign up.ready = !valid || dn.ready;
  assign dn.valid = valid;
  assign dn.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up.ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      data <= up.data;
    end
  end

endmodule

FILE: rtl/core/z80alu_core.sv
// ----------------------------------------------------------------------------
// z80alu_core
// Result and flag logic for one operation; handshake passes straight through.
// ----------------------------------------------------------------------------
module z80alu_core (
  z80alu_if.sink   op,
  z80alu_if.source res
);

  localparam logic [7:0] INC_OVF = 8'h7F;
  localparam logic [7:0] DEC_OVF = 8'h80;

  function automatic logic even_par(input logic [7:0] v);
    even_par = ~^v;
  endfunction

  assign res.valid = op.valid;
  assign op.ready  = res.ready;

  logic [4:0]  func;
  logic [15:0] a16, b16;
  logic [7:0]  a, b;
  logic        c;

  assign func = op.data.func;
  assign a16  = op.data.operand_a;
  assign b16  = op.data.operand_b;
  assign a    = a16[7:0];
  assign b    = b16[7:0];
  assign c    = op.data.flags_in[z80alu_pkg::FL_C];

  // 8-bit and 16-bit adders/subtractors with carry-in
  logic       cin8, cin16;
  logic [8:0] sum8, dif8;
  logic [4:0] hsum8, hdif8;
  logic [16:0] sum16, dif16;
  logic [12:0] hsum16, hdif16;
  logic [7:0]  mask;

  assign cin8  = (func == z80alu_pkg::OP_ADC || func == z80alu_pkg::OP_SBC) ? c : 1'b0;
  assign cin16 = (func == z80alu_pkg::OP_ADC16) ? c : 1'b0;

  assign sum8   = {1'b0, a} + {1'b0, b} + 9'(cin8);
  assign dif8   = {1'b0, a} - {1'b0, b} - 9'(cin8);
  assign hsum8  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin8);
  assign hdif8  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(cin8);
  assign sum16  = {1'b0, a16} + {1'b0, b16} + 17'(cin16);
  assign dif16  = {1'b0, a16} - {1'b0, b16} - 17'(c);
  assign hsum16 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]} + 13'(cin16);
  assign hdif16 = {1'b0, a16[11:0]} - {1'b0, b16[11:0]} - 13'(c);
  assign mask   = 8'(8'd1 << op.data.bit_index);

  always_comb begin
    logic [7:0]  f;
    logic [7:0]  r8;
    logic [15:0] r;
    logic [7:0]  t;
    f  = op.data.flags_in;
    r8 = 8'h00;
    r  = a16;
    t  = a & mask;
    case (func)
      z80alu_pkg::OP_ADD, z80alu_pkg::OP_ADC: begin
        r8 = sum8[7:0];
        f[z80alu_pkg::FL_H]  = hsum8[4];
        f[z80alu_pkg::FL_C]  = sum8[8];
        f[z80alu_pkg::FL_PV] = ~(a[7] ^ b[7]) & (a[7] ^ r8[7]);
        f[z80alu_pkg::FL_S]  = r8[7];
        f[z80alu_pkg::FL_Z]  = (r8 == 8'h00);
        f[z80alu_pkg::FL_N]  = 1'b0;
        r = {8'h00, r8};
      end
      z80alu_pkg::OP_SUB, z80alu_pkg::OP_SBC, z80alu_pkg::OP_CP: begin
        r8 = dif8[7:0];
        f[z80alu_pkg::FL_H]  = hdif8[4];
        f[z80alu_pkg::FL_C]  = dif8[8];
        f[z80alu_pkg::FL_PV] = (a[7] ^ b[7]) & (a[7] ^ r8[7]);
        f[z80alu_pkg::FL_S]  = r8[7];
        f[z80alu_pkg::FL_Z]  = (r8 == 8'h00);
        f[z80alu_pkg::FL_N]  = 1'b1;
        // compare keeps the accumulator
        r = (func == z80alu_pkg::OP_CP) ? {8'h00, a} : {8'h00, r8};
      end
      z80alu_pkg::OP_AND, z80alu_pkg::OP_OR, z80alu_pkg::OP_XOR: begin
        r8 = (func == z80alu_pkg::OP_AND) ? (a & b) :
             (func == z80alu_pkg::OP_OR)  ? (a | b) : (a ^ b);
        f[z80alu_pkg::FL_S]  = r8[7];
        f[z80alu_pkg::FL_Z]  = (r8 == 8'h00);
        f[z80alu_pkg::FL_PV] = even_par(r8);
        f[z80alu_pkg::FL_H]  = (func == z80alu_pkg::OP_AND);
        f[z80alu_pkg::FL_N]  = 1'b0;
        f[z80alu_pkg::FL_C]  = 1'b0;
        r = {8'h00, r8};
      end
      z80alu_pkg::OP_INC: begin
        r8 = a + 8'd1;
        f[z80alu_pkg::FL_S]  = r8[7];
        f[z80alu_pkg::FL_Z]  = (r8 == 8'h00);
        f[z80alu_pkg::FL_PV] = (a == INC_OVF);
        f[z80alu_pkg::FL_N]  = 1'b0;
        f[z80alu_pkg::FL_H]  = (a[3:0] == 4'hF);
        r = {8'h00, r8};
      end
      z80alu_pkg::OP_DEC: begin
        r8 = a - 8'd1;
        f[z80alu_pkg::FL_S]  = r8[7];
        f[z80alu_pkg::FL_Z]  = (r8 == 8'h00);
        f[z80alu_pkg::FL_PV] = (a == DEC_OVF);
        f[z80alu_pkg::FL_N]  = 1'b1;
        f[z80alu_pkg::FL_H]  = (a[3:0] == 4'h0);
        r = {8'h00, r8};
      end
      z80alu_pkg::OP_ADD16, z80alu_pkg::OP_ADC16: begin
        r = sum16[15:0];
        f[z80alu_pkg::FL_H] = hsum16[12];
        f[z80alu_pkg::FL_N] = 1'b0;
        f[z80alu_pkg::FL_C] = sum16[16];
        if (func == z80alu_pkg::OP_ADC16) begin
          f[z80alu_pkg::FL_S]  = r[15];
          f[z80alu_pkg::FL_Z]  = (r == 16'h0000);
          f[z80alu_pkg::FL_PV] = ~(a16[15] ^ b16[15]) & (a16[15] ^ r[15]);
        end
      end
      z80alu_pkg::OP_SBC16: begin
        r = dif16[15:0];
        f[z80alu_pkg::FL_S]  = r[15];
        f[z80alu_pkg::FL_Z]  = (r == 16'h0000);
        f[z80alu_pkg::FL_H]  = hdif16[12];
        f[z80alu_pkg::FL_PV] = (a16[15] ^ b16[15]) & (a16[15] ^ r[15]);
        f[z80alu_pkg::FL_N]  = 1'b1;
        f[z80alu_pkg::FL_C]  = dif16[16];
      end
      z80alu_pkg::OP_INC16: r = a16 + 16'd1;
      z80alu_pkg::OP_DEC16: r = a16 - 16'd1;
      z80alu_pkg::OP_RLC, z80alu_pkg::OP_RL, z80alu_pkg::OP_RRC, z80alu_pkg::OP_RR,
      z80alu_pkg::OP_RLCA, z80alu_pkg::OP_RLA, z80alu_pkg::OP_RRCA, z80alu_pkg::OP_RRA: begin
        if (func inside {z80alu_pkg::OP_RLC, z80alu_pkg::OP_RLCA}) begin
          r8 = {a[6:0], a[7]};
          f[z80alu_pkg::FL_C] = a[7];
        end else if (func inside {z80alu_pkg::OP_RL, z80alu_pkg::OP_RLA}) begin
          r8 = {a[6:0], c};
          f[z80alu_pkg::FL_C] = a[7];
        end else if (func inside {z80alu_pkg::OP_RRC, z80alu_pkg::OP_RRCA}) begin
          r8 = {a[0], a[7:1]};
          f[z80alu_pkg::FL_C] = a[0];
        end else begin
          r8 = {c, a[7:1]};
          f[z80alu_pkg::FL_C] = a[0];
        end
        f[z80alu_pkg::FL_H] = 1'b0;
        f[z80alu_pkg::FL_N] = 1'b0;
        // accumulator forms leave S, Z and PV alone
        if (func <= z80alu_pkg::OP_RR) begin
          f[z80alu_pkg::FL_S]  = r8[7];
          f[z80alu_pkg::FL_Z]  = (r8 == 8'h00);
          f[z80alu_pkg::FL_PV] = even_par(r8);
        end
        r = {8'h00, r8};
      end
      z80alu_pkg::OP_SLA, z80alu_pkg::OP_SRA, z80alu_pkg::OP_SRL, z80alu_pkg::OP_SLL: begin
        if (func inside {z80alu_pkg::OP_SLA, z80alu_pkg::OP_SLL}) begin
          r8 = {a[6:0], (func == z80alu_pkg::OP_SLL)};
          f[z80alu_pkg::FL_C] = a[7];
        end else begin
          r8 = {(func == z80alu_pkg::OP_SRA) & a[7], a[7:1]};
          f[z80alu_pkg::FL_C] = a[0];
        end
        f[z80alu_pkg::FL_S]  = r8[7];
        f[z80alu_pkg::FL_Z]  = (r8 == 8'h00);
        f[z80alu_pkg::FL_PV] = even_par(r8);
        f[z80alu_pkg::FL_H]  = 1'b0;
        f[z80alu_pkg::FL_N]  = 1'b0;
        r = {8'h00, r8};
      end
      z80alu_pkg::OP_BIT: begin
        f[z80alu_pkg::FL_S]  = t[7];
        f[z80alu_pkg::FL_PV] = (t == 8'h00);
        f[z80alu_pkg::FL_Z]  = (t == 8'h00);
        f[z80alu_pkg::FL_H]  = 1'b1;
        f[z80alu_pkg::FL_N]  = 1'b0;
        r = {8'h00, a};
      end
      z80alu_pkg::OP_SET: r = {8'h00, a | mask};
      z80alu_pkg::OP_RES: r = {8'h00, a & ~mask};
      default: r = a16;
    endcase
    res.data.result    = r;
    res.data.flags_out = f;
  end

endmodule

FILE: rtl/core/z80_alu_with_flags.sv
// ----------------------------------------------------------------------------
// z80_alu_with_flags
// Z80 ALU with flag generation, registered on both sides.
// ----------------------------------------------------------------------------
// Path: input register, then the combinational ALU logic, then the result register.
// Throughput: one item per cycle unless a held response stalls; the ALU
//   logic between the two registers is combinational result and flag logic.
// Backpressure: a held response stalls the result register; the input
//   register still takes an item while it is empty.
// Reset: rst (synchronous) clears both valid bits; payload is not reset.
module z80_alu_with_flags (
  input logic clk,
  input logic rst,
  z80alu_if.sink   req,
  z80alu_if.source rsp
);

  // Request held in the input register, fed straight to the ALU logic
  z80alu_if #(.payload_t(z80alu_pkg::req_t)) op_ch ();
  // ALU output, captured by the result register
  z80alu_if #(.payload_t(z80alu_pkg::rsp_t)) res_ch ();

  // Input register: accepts whenever it is empty or its item moves on.
  z80alu_stage #(.payload_t(z80alu_pkg::req_t)) u_in_stage (
    .clk (clk),
    .rst (rst),
    .up  (req),
    .dn  (op_ch)
  );

  // One-pass result and flag logic.
  z80alu_core u_core (
    .op  (op_ch),
    .res (res_ch)
  );

  // Result register: holds the response until the consumer takes it.
  z80alu_stage #(.payload_t(z80alu_pkg::rsp_t)) u_out_stage (
    .clk (clk),
    .rst (rst),
    .up  (res_ch),
    .dn  (rsp)
  );

endmodule

FILE: tb/sv/z80_alu_with_flags_test.sv
// ----------------------------------------------------------------------------
// z80_alu_with_flags_test
// Self-checking bench for the Z80 ALU. Operations go in on the request
// channel and results are matched in order against a bit-exact model of
// the ALU and its flag rules. The request side sends in bursts with gaps and
// the response side stalls in several patterns.
// ----------------------------------------------------------------------------
module z80_alu_with_flags_test;
  timeunit 1ns;
  timeprecision 1ps;

  import z80alu_pkg::*;

  // Codes past OP_RES are spare; the ALU passes operand_a through on them.
  localparam logic [4:0] FUNC_SPARE_LO = 5'd30;
  localparam logic [4:0] FUNC_SPARE_HI = 5'd31;

  // Cycles with no handshake on either side before the run is called hung.
  localparam int STALL_LIMIT = 1000;
  // Idle cycles waited at the end, after every owed result is back.
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS = 700;

  // Operand values that sit on carry, overflow and sign boundaries.
  localparam logic [15:0] EDGE_WORDS [10] = '{
    16'h0000, 16'hFFFF, 16'h007F, 16'h0080, 16'h00FF,
    16'h0FFF, 16'h1000, 16'h7FFF, 16'h8000, 16'h0001
  };

  logic clk;
  logic rst;

  z80alu_if #(.payload_t(req_t)) req_ch ();
  z80alu_if #(.payload_t(rsp_t)) rsp_ch ();

  z80_alu_with_flags dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // In-order store of the results the ALU owes us.
  rsp_t        alu_results_due [$];
  func_t       alu_ops_due [$];

  int          failures;
  int          items_sent;
  int          results_checked;
  int          burst_left;
  logic [31:0] codes_hit;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the ALU: result word and new flag byte for one operation.
  // Untouched flags, bits 5 and 3 included, ride through from flags_in.
  // --------------------------------------------------------------------------
  function automatic rsp_t alu_predict(req_t rq);
    logic [7:0]  a, b, r8, f;
    logic [15:0] a16, b16, r16;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [16:0] sum17;
    logic [12:0] low12;
    logic [4:0]  rot;
    logic        cy, cin, out_bit, fill, tested, left;
    func_t       op;
    rsp_t        rs;
    a   = rq.operand_a[7:0];
    b   = rq.operand_b[7:0];
    a16 = rq.operand_a;
    b16 = rq.operand_b;
    f   = rq.flags_in;
    cy  = f[FL_C];
    r8  = '0;
    r16 = '0;
    op  = func_t'(rq.func);
    case (op)
      OP_ADD, OP_ADC: begin
        cin      = (op == OP_ADC) ? cy : 1'b0;
        sum9     = {1'b0, a} + {1'b0, b} + 9'(cin);
        nib      = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin);
        r8       = sum9[7:0];
        f[FL_H]  = nib[4];
        f[FL_C]  = sum9[8];
        f[FL_PV] = ~(a[7] ^ b[7]) & (a[7] ^ r8[7]);
        f[FL_S]  = r8[7];
        f[FL_Z]  = (r8 == 8'h00);
        f[FL_N]  = 1'b0;
        r16      = {8'h00, r8};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cin      = (op == OP_SBC) ? cy : 1'b0;
        r8       = a - b - 8'(cin);
        f[FL_H]  = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + 5'(cin));
        f[FL_C]  = {1'b0, a} < ({1'b0, b} + 9'(cin));
        f[FL_PV] = (a[7] ^ b[7]) & (a[7] ^ r8[7]);
        f[FL_S]  = r8[7];
        f[FL_Z]  = (r8 == 8'h00);
        f[FL_N]  = 1'b1;
        // compare sets flags from the difference but hands back A
        r16      = (op == OP_CP) ? {8'h00, a} : {8'h00, r8};
      end
      OP_AND, OP_OR, OP_XOR: begin
        r8       = (op == OP_AND) ? (a & b) : (op == OP_OR) ? (a | b) : (a ^ b);
        f[FL_S]  = r8[7];
        f[FL_Z]  = (r8 == 8'h00);
        f[FL_PV] = ~^r8;
        f[FL_H]  = (op == OP_AND);
        f[FL_N]  = 1'b0;
        f[FL_C]  = 1'b0;
        r16      = {8'h00, r8};
      end
      OP_INC, OP_DEC: begin
        r8       = (op == OP_INC) ? a + 8'h01 : a - 8'h01;
        f[FL_S]  = r8[7];
        f[FL_Z]  = (r8 == 8'h00);
        f[FL_PV] = (op == OP_INC) ? (a == 8'h7F) : (a == 8'h80);
        f[FL_N]  = (op == OP_DEC);
        f[FL_H]  = (op == OP_INC) ? (a[3:0] == 4'hF) : (a[3:0] == 4'h0);
        r16      = {8'h00, r8};
      end
      OP_ADD16, OP_ADC16: begin
        cin     = (op == OP_ADC16) ? cy : 1'b0;
        sum17   = {1'b0, a16} + {1'b0, b16} + 17'(cin);
        low12   = {1'b0, a16[11:0]} + {1'b0, b16[11:0]} + 13'(cin);
        r16     = sum17[15:0];
        f[FL_H] = low12[12];
        f[FL_N] = 1'b0;
        f[FL_C] = sum17[16];
        // plain 16-bit add keeps S, Z and PV
        if (op == OP_ADC16) begin
          f[FL_S]  = r16[15];
          f[FL_Z]  = (r16 == 16'h0000);
          f[FL_PV] = ~(a16[15] ^ b16[15]) & (a16[15] ^ r16[15]);
        end
      end
      OP_SBC16: begin
        r16      = a16 - b16 - 16'(cy);
        f[FL_S]  = r16[15];
        f[FL_Z]  = (r16 == 16'h0000);
        f[FL_H]  = {1'b0, a16[11:0]} < ({1'b0, b16[11:0]} + 13'(cy));
        f[FL_PV] = (a16[15] ^ b16[15]) & (a16[15] ^ r16[15]);
        f[FL_N]  = 1'b1;
        f[FL_C]  = {1'b0, a16} < ({1'b0, b16} + 17'(cy));
      end
      OP_INC16: r16 = a16 + 16'h0001;
      OP_DEC16: r16 = a16 - 16'h0001;
      OP_RLC, OP_RL, OP_RRC, OP_RR, OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
        // low two bits pick rlc / rl / rrc / rr for both forms
        rot     = rq.func - OP_RLC;
        left    = ~rot[1];
        out_bit = left ? a[7] : a[0];
        fill    = rot[0] ? cy : out_bit;
        r8      = left ? {a[6:0], fill} : {fill, a[7:1]};
        f[FL_C] = out_bit;
        f[FL_H] = 1'b0;
        f[FL_N] = 1'b0;
        // accumulator forms leave S, Z and PV alone
        if (op <= OP_RR) begin
          f[FL_S]  = r8[7];
          f[FL_Z]  = (r8 == 8'h00);
          f[FL_PV] = ~^r8;
        end
        r16 = {8'h00, r8};
      end
      OP_SLA, OP_SRA, OP_SRL, OP_SLL: begin
        if (op == OP_SLA || op == OP_SLL) begin
          f[FL_C] = a[7];
          r8      = {a[6:0], (op == OP_SLL)};
        end else begin
          f[FL_C] = a[0];
          r8      = {(op == OP_SRA) ? a[7] : 1'b0, a[7:1]};
        end
        f[FL_S]  = r8[7];
        f[FL_Z]  = (r8 == 8'h00);
        f[FL_PV] = ~^r8;
        f[FL_H]  = 1'b0;
        f[FL_N]  = 1'b0;
        r16      = {8'h00, r8};
      end
      OP_BIT: begin
        tested   = a[rq.bit_index];
        f[FL_S]  = (rq.bit_index == 3'd7) & tested;
        f[FL_PV] = ~tested;
        f[FL_Z]  = ~tested;
        f[FL_H]  = 1'b1;
        f[FL_N]  = 1'b0;
        r16      = {8'h00, a};
      end
      OP_SET: r16 = {8'h00, a | (8'h01 << rq.bit_index)};
      OP_RES: r16 = {8'h00, a & ~(8'h01 << rq.bit_index)};
      default: r16 = a16;
    endcase
    rs.result    = r16;
    rs.flags_out = f;
    return rs;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Requests are modeled as they are accepted; each accepted
  // result is matched against the oldest expectation. Both handshakes are
  // sampled at the edge, before the nonblocking updates of that step land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    rsp_t  want;
    func_t op;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (alu_results_due.size() == 0) begin
          $error("result item with no request outstanding: result %h flags %h",
                 rsp_ch.data.result, rsp_ch.data.flags_out);
          failures++;
        end else begin
          want = alu_results_due.pop_front();
          op   = alu_ops_due.pop_front();
          results_checked++;
          if (rsp_ch.data.result !== want.result) begin
            $error("result (op %0d): expected %h, actual %h",
                   op, want.result, rsp_ch.data.result);
            failures++;
          end
          if (rsp_ch.data.flags_out !== want.flags_out) begin
            $error("flags_out (op %0d): expected %b, actual %b",
                   op, want.flags_out, rsp_ch.data.flags_out);
            failures++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        alu_results_due.push_back(alu_predict(req_ch.data));
        alu_ops_due.push_back(func_t'(req_ch.data.func));
        codes_hit[req_ch.data.func] = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: ready follows one of four stall patterns, reselected at
  // random during the run: always ready, random, periodic, and long blocks.
  // --------------------------------------------------------------------------
  initial begin : result_stall
    int cyc;
    int mode;
    int hold;
    cyc  = 0;
    mode = 0;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 9) < 6);
        2: rsp_ch.ready <= (cyc % 4 != 0);
        default: begin
          if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
          end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold = $urandom_range(3, 14);
          end
        end
      endcase
    end
  end

  // Hang detector: any handshake on either side resets the count.
  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stale = 0;
      else stale++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("FAIL z80_alu_with_flags");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request side. Items go out in bursts of random length; between bursts
  // valid drops for a random gap, sometimes none. valid stays high from one
  // item to the next within a burst. Returns at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input req_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.data  <= item;
    req_ch.valid <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_op(input logic [4:0] func, input logic [15:0] opa,
                         input logic [15:0] opb, input logic [2:0] bidx,
                         input logic [7:0] flags);
    req_t item;
    item.func      = func;
    item.operand_a = opa;
    item.operand_b = opb;
    item.bit_index = bidx;
    item.flags_in  = flags;
    send_item(item);
  endtask

  // Hold off the request side until every owed result is back. The first
  // edge lets the scoreboard log the item accepted at this step.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (alu_results_due.size() != 0);
  endtask

  // 8-bit add/subtract family: overflow, carry, borrow, zero, compare.
  // Upper bytes carry junk that must not leak into 8-bit results.
  task automatic test_arith8();
    send_op(OP_ADD, 16'hFF7F, 16'hAA01, 3'd0, 8'h00);  // signed overflow, H
    send_op(OP_ADC, 16'h00FF, 16'hFF00, 3'd0, 8'hFF);  // carry in -> zero, C
    send_op(OP_SUB, 16'h0080, 16'h0001, 3'd0, 8'h28);  // overflow on sub
    send_op(OP_SBC, 16'hFF00, 16'h00FF, 3'd0, 8'h01);  // borrow through
    send_op(OP_CP,  16'h1212, 16'h0034, 3'd0, 8'h00);  // result stays A
    send_op(OP_INC, 16'h007F, 16'h0000, 3'd0, 8'hD7);  // 7F -> 80 sets PV
    send_op(OP_DEC, 16'hFF80, 16'h0000, 3'd0, 8'h01);  // 80 -> 7F sets PV
  endtask

  task automatic test_logic8();
    send_op(OP_AND, 16'h00F0, 16'h000F, 3'd0, 8'hFF);  // zero result
    send_op(OP_OR,  16'h0055, 16'hFFAA, 3'd0, 8'h00);
    send_op(OP_XOR, 16'hFFFF, 16'h0000, 3'd0, 8'h28);
  endtask

  // 16-bit ops; plain ADD16 must keep S/Z/PV, INC16/DEC16 keep every flag.
  task automatic test_arith16();
    send_op(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 8'hC4);
    send_op(OP_ADC16, 16'h7FFF, 16'h0000, 3'd0, 8'h01);
    send_op(OP_SBC16, 16'h0000, 16'hFFFF, 3'd0, 8'h01);
    send_op(OP_INC16, 16'hFFFF, 16'h1234, 3'd0, 8'hAA);
    send_op(OP_DEC16, 16'h0000, 16'h1234, 3'd0, 8'h55);
  endtask

  // Rotates in both forms and shifts; accumulator forms touch only C/H/N.
  task automatic test_rotate_shift();
    send_op(OP_RLC,  16'h0080, 16'h0000, 3'd0, 8'h00);
    send_op(OP_RL,   16'h0080, 16'h0000, 3'd0, 8'h01);
    send_op(OP_RRC,  16'h0001, 16'h0000, 3'd0, 8'h00);
    send_op(OP_RR,   16'h0001, 16'h0000, 3'd0, 8'h00);
    send_op(OP_RLCA, 16'hFF81, 16'h0000, 3'd0, 8'hFF);
    send_op(OP_RLA,  16'h0040, 16'h0000, 3'd0, 8'hC5);
    send_op(OP_RRCA, 16'h0001, 16'h0000, 3'd0, 8'h12);
    send_op(OP_RRA,  16'h0000, 16'h0000, 3'd0, 8'hFF);
    send_op(OP_SLA,  16'h0080, 16'h0000, 3'd0, 8'h00);
    send_op(OP_SRA,  16'h0081, 16'h0000, 3'd0, 8'h00);
    send_op(OP_SRL,  16'h0001, 16'h0000, 3'd0, 8'hFF);
    send_op(OP_SLL,  16'h0000, 16'h0000, 3'd0, 8'h00);
  endtask

  // BIT on bit 7 set drives S; BIT on a clear bit sets Z and PV together.
  task automatic test_bit_ops();
    send_op(OP_BIT, 16'h0080, 16'h0000, 3'd7, 8'h01);
    send_op(OP_BIT, 16'hFFFE, 16'h0000, 3'd0, 8'h00);
    send_op(OP_SET, 16'h0000, 16'h0000, 3'd7, 8'hFF);
    send_op(OP_RES, 16'hFFFF, 16'h0000, 3'd0, 8'h00);
  endtask

  task automatic test_spare_codes();
    send_op(FUNC_SPARE_LO, 16'hBEEF, 16'hFFFF, 3'd7, 8'hA5);
    send_op(FUNC_SPARE_HI, 16'h8001, 16'h0000, 3'd0, 8'h5A);
  endtask

  function automatic logic [15:0] pick_operand();
    if ($urandom_range(0, 3) == 0) return EDGE_WORDS[$urandom_range(0, 9)];
    return 16'($urandom);
  endfunction

  // Mostly legal codes, a few spares; operand_b sometimes equals operand_a
  // so that zero results and equal compares come up often.
  function automatic req_t random_request();
    req_t item;
    item.func = ($urandom_range(0, 15) == 0)
              ? 5'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI))
              : 5'($urandom_range(OP_ADD, OP_RES));
    item.operand_a = pick_operand();
    item.operand_b = ($urandom_range(0, 7) == 0) ? item.operand_a : pick_operand();
    item.bit_index = 3'($urandom_range(0, 7));
    item.flags_in  = 8'($urandom_range(0, 255));
    return item;
  endfunction

  // Back-to-back run with no sender gaps, then drain before moving on.
  task automatic test_back_to_back();
    burst_left = 16;
    repeat (16) send_item(random_request());
    wait_for_results();
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_request());
      // drain now and then so the pipeline restarts from empty
      if (i % 175 == 174) wait_for_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run
    failures        = 0;
    items_sent      = 0;
    results_checked = 0;
    burst_left      = 0;
    codes_hit       = '0;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_arith8();
    test_logic8();
    test_arith16();
    test_rotate_shift();
    test_bit_ops();
    test_spare_codes();
    test_back_to_back();
    test_random_mix(RANDOM_ITEMS);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (alu_results_due.size() != 0) begin
      $error("%0d expected results never arrived", alu_results_due.size());
      failures++;
    end

    $display("Sent %0d ALU items over %0d distinct op codes; %0d results checked.",
             items_sent, $countones(codes_hit), results_checked);
    $display("Mismatches and protocol errors: %0d.", failures);
    if (failures == 0) begin
      $display("PASS z80_alu_with_flags");
    end else begin
      $display("FAIL z80_alu_with_flags");
    end
    $finish;
  end

endmodule
